>>> hdl/hmlp_pkg.sv
// Shared constants, codes and types of the linear-probe hash map.
package hmlp_pkg;

  localparam int unsigned KEY_W = 64;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned STS_W = 2;
  localparam int unsigned CNT_W = 11;
  localparam int unsigned SLOT_W = KEY_W + VAL_W;

  localparam int unsigned SLOTS_DEF = 1024;

  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 11'd768;

  // Hash finalizer constants
  localparam logic [KEY_W-1:0] MIX_C1 = 64'hbf58476d1ce4e5b9;
  localparam logic [KEY_W-1:0] MIX_C2 = 64'h94d049bb133111eb;
  localparam int unsigned MIX_S1 = 30;
  localparam int unsigned MIX_S2 = 27;
  localparam int unsigned MIX_S3 = 31;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STS_W-1:0] STS_OK     = 2'd0;
  localparam logic [STS_W-1:0] STS_BADKEY = 2'd1;
  localparam logic [STS_W-1:0] STS_FULL   = 2'd2;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

endpackage

>>> hdl/hmlp_hash.sv
// Five-stage pipelined 64-bit mix hash producing the home slot index.
module hmlp_hash import hmlp_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [KEY_W-1:0]         key_i,
  output logic                     done_o,
  output logic [$clog2(SLOTS)-1:0] home_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned HW    = KEY_W / 2;
  localparam int unsigned STG   = 5;

  logic [STG-1:0]   vld_q, vld_d;
  logic [KEY_W-1:0] a_q, a_d;
  logic [KEY_W-1:0] p0_q, p0_d;
  logic [HW-1:0]    p1_q, p1_d, p2_q, p2_d;
  logic [KEY_W-1:0] b_q, b_d;
  logic [KEY_W-1:0] q0_q, q0_d;
  logic [HW-1:0]    q1_q, q1_d, q2_q, q2_d;
  logic [IDX_W-1:0] home_q, home_d;
  logic [KEY_W-1:0] m1, m2, h;

  assign vld_d = {vld_q[STG-2:0], start_i};

  always_comb begin
    a_d  = key_i ^ (key_i >> MIX_S1);
    // low 64 bits of a * C1 from three 32x32 partial products
    p0_d = 64'(a_q[HW-1:0]) * 64'(MIX_C1[HW-1:0]);
    p1_d = HW'(a_q[KEY_W-1:HW] * MIX_C1[HW-1:0]);
    p2_d = HW'(a_q[HW-1:0] * MIX_C1[KEY_W-1:HW]);
    m1   = p0_q + {p1_q + p2_q, {HW{1'b0}}};
    b_d  = m1 ^ (m1 >> MIX_S2);
    q0_d = 64'(b_q[HW-1:0]) * 64'(MIX_C2[HW-1:0]);
    q1_d = HW'(b_q[KEY_W-1:HW] * MIX_C2[HW-1:0]);
    q2_d = HW'(b_q[HW-1:0] * MIX_C2[KEY_W-1:HW]);
    m2   = q0_q + {q1_q + q2_q, {HW{1'b0}}};
    h    = m2 ^ (m2 >> MIX_S3);
    // SLOTS is a power of two: the modulo is the low bits
    home_d = h[IDX_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    p0_q   <= p0_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    b_q    <= b_d;
    q0_q   <= q0_d;
    q1_q   <= q1_d;
    q2_q   <= q2_d;
    home_q <= home_d;
  end

  assign done_o = vld_q[STG-1];
  assign home_o = home_q;

endmodule

>>> hdl/hmlp_mem.sv
// Slot memory holding key and value per slot, one write and one registered read port.
module hmlp_mem import hmlp_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                     clk_i,
  input  mem_ctl_t                 ctl_i,
  input  logic [$clog2(SLOTS)-1:0] rd_addr_i,
  input  logic [$clog2(SLOTS)-1:0] wr_addr_i,
  input  logic [SLOT_W-1:0]        wr_data_i,
  output logic [SLOT_W-1:0]        rd_data_o
);

  logic [SLOT_W-1:0] mem_q [SLOTS];
  logic [SLOT_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/hash_map_linear_probe_i64_u32.sv
// Top level of the linear-probe hash map: command sequencer, entry count and output register.
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid_i / in_stall_o | in_cmd_i, in_key_i, in_value_i
//   out     | output    | out_valid_o / out_stall_i | out_status_o, out_found_o,
//           |           |                        | out_read_value_o, out_entry_count_o
//   cfg     | input     | cfg_we_i               | cfg_wdata_i (max_entries)
//
// Insert and lookup pass the hash pipeline, then probe P slots, P being the number of slots
// probed (one slot read per cycle from the slot memory), before the result.
// Key zero and unused commands skip the hash. Clear sweeps the memory before its result.
// After reset a sweep empties the memory; items are held off meanwhile.
// A waiting result sits in the output register; the next item is taken while it is stalled.
// SLOTS must be a power of two.
module hash_map_linear_probe_i64_u32 import hmlp_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [CNT_W-1:0]        cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [CMD_W-1:0]        in_cmd_i,
  input  logic signed [KEY_W-1:0] in_key_i,
  input  logic [VAL_W-1:0]        in_value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [STS_W-1:0]        out_status_o,
  output logic                    out_found_o,
  output logic [VAL_W-1:0]        out_read_value_o,
  output logic [CNT_W-1:0]        out_entry_count_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned OCC_W = IDX_W + 1;
  localparam int unsigned CMP_W = (OCC_W > CNT_W) ? OCC_W : CNT_W;

  localparam logic [2:0] ST_SWEEP = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0]       state_q, state_d;
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic             clr_pend_q, clr_pend_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [CNT_W-1:0] max_q;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [CMD_W-1:0] cmd_q, cmd_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [STS_W-1:0] res_sts_q, res_sts_d;
  logic             res_fnd_q, res_fnd_d;
  logic [VAL_W-1:0] res_val_q, res_val_d;

  logic             out_valid_q, out_valid_d;
  logic [STS_W-1:0] out_sts_q;
  logic             out_fnd_q;
  logic [VAL_W-1:0] out_val_q;
  logic [CNT_W-1:0] out_cnt_q;
  logic             out_load;

  logic             in_acc;
  logic             hash_start;
  logic             hash_done;
  logic [IDX_W-1:0] hash_home;

  mem_ctl_t          mem_ctl;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic [SLOT_W-1:0] wr_data, rd_data;
  logic [KEY_W-1:0]  slot_key;
  logic [VAL_W-1:0]  slot_val;
  logic              slot_empty, slot_hit, probe_wrap, at_limit;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign hash_start = in_acc && (in_key_i != '0)
                      && ((in_cmd_i == CMD_INSERT) || (in_cmd_i == CMD_LOOKUP));

  hmlp_hash #(
    .SLOTS (SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (in_key_i),
    .done_o  (hash_done),
    .home_o  (hash_home)
  );

  hmlp_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk_i     (clk_i),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  assign slot_key   = rd_data[SLOT_W-1:VAL_W];
  assign slot_val   = rd_data[VAL_W-1:0];
  assign slot_empty = (slot_key == '0);
  assign slot_hit   = (slot_key == key_q);
  assign probe_wrap = (cnt_q == {IDX_W{1'b1}});
  assign at_limit   = CMP_W'(occ_q) >= CMP_W'(max_q);
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d    = state_q;
    sweep_d    = sweep_q;
    clr_pend_d = clr_pend_q;
    occ_d      = occ_q;
    cur_d      = cur_q;
    cnt_d      = cnt_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    val_d      = val_q;
    res_sts_d  = res_sts_q;
    res_fnd_d  = res_fnd_q;
    res_val_d  = res_val_q;
    mem_ctl    = '0;
    rd_addr    = cur_q + 1'b1;
    wr_addr    = cur_q;
    wr_data    = {key_q, val_q};

    case (state_q)
      ST_SWEEP: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = sweep_q;
        wr_data       = '0;
        sweep_d       = sweep_q + 1'b1;
        if (sweep_q == {IDX_W{1'b1}}) begin
          state_d    = clr_pend_q ? ST_DONE : ST_IDLE;
          clr_pend_d = 1'b0;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          cmd_d     = in_cmd_i;
          key_d     = in_key_i;
          val_d     = in_value_i;
          res_sts_d = STS_OK;
          res_fnd_d = 1'b0;
          res_val_d = '0;
          case (in_cmd_i)
            CMD_INSERT, CMD_LOOKUP: begin
              if (in_key_i == '0) begin
                res_sts_d = STS_BADKEY;
                state_d   = ST_DONE;
              end else begin
                state_d = ST_HASH;
              end
            end
            CMD_CLEAR: begin
              occ_d      = '0;
              clr_pend_d = 1'b1;
              sweep_d    = '0;
              state_d    = ST_SWEEP;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_HASH: begin
        if (hash_done) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr       = hash_home;
          cur_d         = hash_home;
          cnt_d         = '0;
          state_d       = ST_PROBE;
        end
      end
      ST_PROBE: begin
        // read the next slot ahead; drop it when this one ends the probe
        mem_ctl.rd_en = 1'b1;
        if (slot_hit) begin
          state_d = ST_DONE;
          if (cmd_q == CMD_INSERT) begin
            mem_ctl.wr_en = 1'b1;
          end else begin
            res_fnd_d = 1'b1;
            res_val_d = slot_val;
          end
        end else if (slot_empty || probe_wrap) begin
          state_d = ST_DONE;
          if (cmd_q == CMD_INSERT) begin
            if (slot_empty && !at_limit) begin
              mem_ctl.wr_en = 1'b1;
              occ_d         = occ_q + 1'b1;
            end else begin
              res_sts_d = STS_FULL;
            end
          end
        end else begin
          cur_d = cur_q + 1'b1;
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DONE: begin
        // the next item's first slot read comes after the hash pipeline,
        // well past this item's write
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      clr_pend_q  <= 1'b0;
      occ_q       <= '0;
      max_q       <= MAX_ENTRIES_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      clr_pend_q  <= clr_pend_d;
      occ_q       <= occ_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    cnt_q     <= cnt_d;
    cmd_q     <= cmd_d;
    key_q     <= key_d;
    val_q     <= val_d;
    res_sts_q <= res_sts_d;
    res_fnd_q <= res_fnd_d;
    res_val_q <= res_val_d;
    if (out_load) begin
      out_sts_q <= res_sts_q;
      out_fnd_q <= res_fnd_q;
      out_val_q <= res_val_q;
      out_cnt_q <= CNT_W'(occ_q);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_status_o      = out_sts_q;
  assign out_found_o       = out_fnd_q;
  assign out_read_value_o  = out_val_q;
  assign out_entry_count_o = out_cnt_q;

  a_wr_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.wr_en |-> (state_q == ST_PROBE || state_q == ST_SWEEP))
    else $error("slot write outside probe or sweep");

  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OCC_W'(SLOTS) >= occ_q)
    else $error("entry count above slot count");

  a_occ_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (occ_q != $past(occ_q) && occ_q != '0) |-> $past(mem_ctl.wr_en))
    else $error("entry count grew without a slot write");

  a_hash_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> (state_q == ST_HASH))
    else $error("hash result outside hash wait");

  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result shown without a finished item");

endmodule
